>>> src/two_pool_handle_table_macros.svh
// assertion helpers for the handle table, clocked on clk, quiet during reset
`ifndef TWO_POOL_HANDLE_TABLE_MACROS_SVH
`define TWO_POOL_HANDLE_TABLE_MACROS_SVH

// same-cycle implication
`define TPHT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("handle table check failed");

// next-cycle implication
`define TPHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("handle table check failed");

`endif

>>> src/tpht_pkg.sv
// ----------------------------------------------------------------------------
// tpht_pkg
// Shared widths, codes and bundles of the two-pool handle table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpht_pkg;

    localparam int ACTION_W          = 2;
    localparam int HANDLE_W          = 16;
    localparam int VALUE_W           = 64;
    localparam int IDX_W             = 12;
    localparam int SCAN_CHUNK        = 64;
    localparam int MAIN_SLOTS_DEF    = 64;
    localparam int SIDE_SLOTS_DEF    = 64;
    localparam int SIDE_FLAG_BIT_DEF = 15;

    localparam logic [VALUE_W-1:0] MARKER_RESET = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_BIND   = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef struct packed {
        logic             wr;
        logic             rd;
        logic             scan;
        logic [IDX_W-1:0] idx;
    } pool_req_t;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [IDX_W-1:0] idx;
    } scan_res_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] new_handle;
        logic                alloc_failed;
        logic [VALUE_W-1:0]  looked_up_value;
    } rsp_word_t;

endpackage

`default_nettype wire

>>> src/tpht_req_if.sv
// ----------------------------------------------------------------------------
// tpht_req_if
// Request channel: one word per allocate, bind or lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tpht_req_if;
    logic                            valid;
    logic                            ready;
    logic [tpht_pkg::ACTION_W-1:0]   action;
    logic                            use_side_pool;
    logic [tpht_pkg::HANDLE_W-1:0]   handle;
    logic [tpht_pkg::VALUE_W-1:0]    bind_value;

    modport source (output valid, action, use_side_pool, handle, bind_value, input ready);
    modport sink   (input valid, action, use_side_pool, handle, bind_value, output ready);
endinterface

`default_nettype wire

>>> src/tpht_rsp_if.sv
// ----------------------------------------------------------------------------
// tpht_rsp_if
// Response channel: one word per allocate or lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tpht_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [tpht_pkg::HANDLE_W-1:0]   new_handle;
    logic                            alloc_failed;
    logic [tpht_pkg::VALUE_W-1:0]    looked_up_value;

    modport source (output valid, new_handle, alloc_failed, looked_up_value, input ready);
    modport sink   (input valid, new_handle, alloc_failed, looked_up_value, output ready);
endinterface

`default_nettype wire

>>> src/two_pool_handle_table.sv
// ----------------------------------------------------------------------------
// two_pool_handle_table
// First-fit handle allocator over a main pool and a flagged side pool.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. A bind writes the pool at the edge that
// takes it and gives no response. A lookup reads the pool memory at the edge
// that takes it; its response is registered from the S_READ state, through
// the hold register if the output is still full. An allocate searches the
// pool's free bitmap 64 entries per cycle from entry 0 up; its response is
// registered once the chunk holding the first free entry, or the last chunk,
// has been searched. Each pool keeps a free bit per entry, set at reset but
// for main pool entry 0, so no clearing pass follows reset. A new request is
// taken as soon as the previous response is registered, even while that
// response still waits on rsp.ready; a second response then waits in a hold
// register and stalls further requests until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
`include "two_pool_handle_table_macros.svh"

module two_pool_handle_table #(
    parameter int MAIN_SLOTS    = tpht_pkg::MAIN_SLOTS_DEF,
    parameter int SIDE_SLOTS    = tpht_pkg::SIDE_SLOTS_DEF,
    parameter int SIDE_FLAG_BIT = tpht_pkg::SIDE_FLAG_BIT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tpht_pkg::VALUE_W-1:0]  cfg_wr_data,
    tpht_req_if.sink                           req,
    tpht_rsp_if.source                         rsp
);

    localparam int HW = tpht_pkg::HANDLE_W;
    localparam logic [HW-1:0] FLAG_MASK =
        (SIDE_FLAG_BIT < HW) ? HW'(32'd1 << SIDE_FLAG_BIT) : '0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_HOLD
    } state_t;

    state_t                        state_reg;
    logic                          side_reg;
    logic [tpht_pkg::VALUE_W-1:0]  marker_reg;
    tpht_pkg::rsp_word_t           res_reg;
    tpht_pkg::rsp_word_t           out_reg;
    logic                          out_valid_reg;

    tpht_pkg::pool_req_t           main_req;
    tpht_pkg::pool_req_t           side_req;
    tpht_pkg::scan_res_t           main_scan;
    tpht_pkg::scan_res_t           side_scan;
    tpht_pkg::scan_res_t           scan_c;
    logic [tpht_pkg::VALUE_W-1:0]  main_value;
    logic [tpht_pkg::VALUE_W-1:0]  side_value;
    logic [tpht_pkg::VALUE_W-1:0]  read_value;
    logic [tpht_pkg::VALUE_W-1:0]  wdata;

    tpht_pkg::action_t             act;
    logic                          acc;
    logic                          is_side;
    logic [HW-1:0]                 hidx;
    logic                          main_ok;
    logic                          side_ok;
    logic                          slot_free;
    logic                          load_out;
    logic                          alloc_hit;
    tpht_pkg::rsp_word_t           res_c;

    assign act       = tpht_pkg::action_t'(req.action);
    assign req.ready = (state_reg == S_IDLE);
    assign acc       = req.valid && req.ready;

    // handle decode: flag bit picks the side pool, the rest is the index
    assign is_side = |(req.handle & FLAG_MASK);
    assign hidx    = req.handle & ~FLAG_MASK;
    assign side_ok = is_side && (32'(hidx) < 32'(SIDE_SLOTS));
    assign main_ok = !is_side && (hidx != '0) && (32'(hidx) < 32'(MAIN_SLOTS));

    assign scan_c    = side_reg ? side_scan : main_scan;
    assign alloc_hit = (state_reg == S_SCAN) && scan_c.done && scan_c.found;
    assign wdata     = (state_reg == S_SCAN) ? marker_reg : req.bind_value;

    always_comb
    begin
        main_req.scan = acc && (act == tpht_pkg::ACT_ALLOC) && !req.use_side_pool;
        main_req.rd   = acc && (act == tpht_pkg::ACT_LOOKUP) && main_ok;
        main_req.wr   = (acc && (act == tpht_pkg::ACT_BIND) && main_ok) ||
                        (alloc_hit && !side_reg);
        main_req.idx  = (state_reg == S_SCAN) ? main_scan.idx : hidx[tpht_pkg::IDX_W-1:0];

        side_req.scan = acc && (act == tpht_pkg::ACT_ALLOC) && req.use_side_pool;
        side_req.rd   = acc && (act == tpht_pkg::ACT_LOOKUP) && side_ok;
        side_req.wr   = (acc && (act == tpht_pkg::ACT_BIND) && side_ok) ||
                        (alloc_hit && side_reg);
        side_req.idx  = (state_reg == S_SCAN) ? side_scan.idx : hidx[tpht_pkg::IDX_W-1:0];
    end

    tpht_pool #(
        .SLOTS     (MAIN_SLOTS),
        .SKIP_ZERO (1'b1)
    ) u_main (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (main_req),
        .wdata    (wdata),
        .rd_value (main_value),
        .scan_res (main_scan)
    );

    tpht_pool #(
        .SLOTS     (SIDE_SLOTS),
        .SKIP_ZERO (1'b0)
    ) u_side (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (side_req),
        .wdata    (wdata),
        .rd_value (side_value),
        .scan_res (side_scan)
    );

    assign read_value = side_reg ? side_value : main_value;

    // response word for the item in flight
    always_comb
    begin
        res_c = '0;
        case (state_reg)
            S_SCAN:
            begin
                res_c.alloc_failed = !scan_c.found;
                if (scan_c.found)
                begin
                    res_c.new_handle = side_reg ? (FLAG_MASK | HW'(scan_c.idx))
                                                : HW'(scan_c.idx);
                end
            end
            S_READ:
            begin
                // a reserved entry reads as zero
                res_c.looked_up_value = (read_value == marker_reg) ? '0 : read_value;
            end
            default:
            begin
                res_c = '0;
            end
        endcase
    end

    assign slot_free = !out_valid_reg || rsp.ready;

    // output register takes a new word this cycle
    assign load_out = slot_free && ((state_reg == S_READ) || (state_reg == S_HOLD) ||
                                    ((state_reg == S_SCAN) && scan_c.done));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            side_reg      <= 1'b0;
            marker_reg    <= tpht_pkg::MARKER_RESET;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
            out_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                marker_reg <= cfg_wr_data;
            end
            if (out_valid_reg && rsp.ready && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        case (act)
                            tpht_pkg::ACT_ALLOC:
                            begin
                                side_reg  <= req.use_side_pool;
                                state_reg <= S_SCAN;
                            end
                            tpht_pkg::ACT_LOOKUP:
                            begin
                                side_reg <= is_side;
                                if (main_ok || side_ok)
                                begin
                                    state_reg <= S_READ;
                                end
                                else
                                begin
                                    // out of range reads as zero
                                    res_reg   <= '0;
                                    state_reg <= S_HOLD;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN, S_READ:
                begin
                    if ((state_reg == S_READ) || scan_c.done)
                    begin
                        if (slot_free)
                        begin
                            out_reg       <= res_c;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            res_reg   <= res_c;
                            state_reg <= S_HOLD;
                        end
                    end
                end
                S_HOLD:
                begin
                    if (slot_free)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.new_handle      = out_reg.new_handle;
    assign rsp.alloc_failed    = out_reg.alloc_failed;
    assign rsp.looked_up_value = out_reg.looked_up_value;

    `TPHT_ASSERT_NOW(a_no_rd_wr_same, 1'b1, !(main_req.wr && main_req.rd) && !(side_req.wr && side_req.rd))
    `TPHT_ASSERT_NOW(a_scan_done_in_scan, main_scan.done || side_scan.done, state_reg == S_SCAN)
    `TPHT_ASSERT_NEXT(a_read_issued, main_req.rd || side_req.rd, state_reg == S_READ)
    `TPHT_ASSERT_NOW(a_fail_no_handle, out_valid_reg && out_reg.alloc_failed, out_reg.new_handle == '0)

endmodule

`default_nettype wire

>>> src/tpht_scan.sv
// ----------------------------------------------------------------------------
// tpht_scan
// First-fit search over a free bitmap, one 64-bit chunk per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpht_scan #(
    parameter int SLOTS = tpht_pkg::MAIN_SLOTS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [SLOTS-1:0]    free_bits,
    output tpht_pkg::scan_res_t      res
);

    localparam int CHUNK  = tpht_pkg::SCAN_CHUNK;
    localparam int NCHUNK = (SLOTS + CHUNK - 1) / CHUNK;
    localparam int PAD    = NCHUNK * CHUNK;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int CIW    = $clog2(CHUNK);

    logic [PAD-1:0]   padded;
    logic [CHUNK-1:0] chunk;
    logic [CIW-1:0]   pos_c;
    logic             found_c;
    logic             last_c;
    logic             busy_reg;
    logic [CW-1:0]    cnt_reg;

    assign padded  = PAD'(free_bits);
    assign chunk   = padded[cnt_reg * CHUNK +: CHUNK];
    assign found_c = |chunk;
    assign last_c  = (cnt_reg == CW'(NCHUNK - 1));

    // lowest set bit of the current chunk
    always_comb
    begin
        pos_c = '0;
        for (int i = CHUNK - 1; i >= 0; i--)
        begin
            if (chunk[i])
            begin
                pos_c = CIW'(i);
            end
        end
    end

    assign res.done  = busy_reg && (found_c || last_c);
    assign res.found = found_c;
    assign res.idx   = (tpht_pkg::IDX_W'(cnt_reg) << CIW) | tpht_pkg::IDX_W'(pos_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (res.done)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/tpht_pool.sv
// ----------------------------------------------------------------------------
// tpht_pool
// One handle pool: value memory, free bitmap and first-fit scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpht_pool #(
    parameter int SLOTS     = tpht_pkg::MAIN_SLOTS_DEF,
    parameter bit SKIP_ZERO = 1'b0
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tpht_pkg::pool_req_t           req,
    input  wire logic [tpht_pkg::VALUE_W-1:0]  wdata,
    output logic [tpht_pkg::VALUE_W-1:0]       rd_value,
    output tpht_pkg::scan_res_t                scan_res
);

    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DEPTH = 1 << AW;

    logic [tpht_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [tpht_pkg::VALUE_W-1:0] data_reg;
    logic [DEPTH-1:0]             free_reg;
    logic                         rfree_reg;
    logic [AW-1:0]                addr;

    assign addr = req.idx[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[addr] <= wdata;
        end
        if (req.rd)
        begin
            data_reg <= mem[addr];
        end
    end

    // a set free bit means the entry reads as zero, whatever the memory holds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                free_reg[i] <= (i < SLOTS) && !(SKIP_ZERO && (i == 0));
            end
            rfree_reg <= 1'b1;
        end
        else
        begin
            if (req.wr)
            begin
                free_reg[addr] <= (wdata == '0);
            end
            if (req.rd)
            begin
                rfree_reg <= free_reg[addr];
            end
        end
    end

    assign rd_value = rfree_reg ? '0 : data_reg;

    tpht_scan #(
        .SLOTS (DEPTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req.scan),
        .free_bits (free_reg),
        .res       (scan_res)
    );

endmodule

`default_nettype wire
